// ===== rtl/core/cdft_pkg.sv =====
// ----------------------------------------------------------------------------
// cdft_pkg
// Shared types, codes and defaults of the corner dedup fan triangulator.
// ----------------------------------------------------------------------------
package cdft_pkg;

  // Default store sizes
  localparam int DEF_MAX_POSITIONS = 4096;
  localparam int DEF_MAX_TEXCOORDS = 4096;
  localparam int DEF_MAX_VERTICES  = 8192;

  // Fixed field widths of the words
  localparam int REF_W  = 32;
  localparam int VIDX_W = 13;
  localparam int AIDX_W = 12;

  // Input item function codes
  typedef enum logic [1:0] {
    FUNC_POS    = 2'd0,
    FUNC_UV     = 2'd1,
    FUNC_CORNER = 2'd2
  } func_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_VERTEX   = 2'd0,
    KIND_TRIANGLE = 2'd1,
    KIND_ERROR    = 2'd2
  } kind_t;

  // Error codes
  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_BAD_REF = 2'd1,
    ERR_FULL    = 2'd2
  } err_t;

  // Face fan progress
  typedef enum logic [1:0] {
    PH_NONE = 2'd0,
    PH_ONE  = 2'd1,
    PH_OPEN = 2'd2
  } phase_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RES_POS,
    ST_RES_UV,
    ST_WALK,
    ST_INSERT,
    ST_FAN
  } state_t;

endpackage

// ===== rtl/core/cdft_ram.sv =====
// ----------------------------------------------------------------------------
// cdft_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cdft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/cdft_ref_resolve.sv =====
// ----------------------------------------------------------------------------
// cdft_ref_resolve
// Shared reference checker: 1-based or negative-from-end reference to index.
// ----------------------------------------------------------------------------
module cdft_ref_resolve
  import cdft_pkg::*;
#(
  parameter int CW = 13
) (
  input  logic [REF_W-1:0] ref_val,
  input  logic [CW-1:0]    count,
  output logic             ok,
  output logic [CW-1:0]    idx
);

  logic [REF_W:0] dec;
  logic [REF_W:0] back;
  logic [REF_W:0] cnt_ext;
  logic           pos_ok;
  logic           neg_ok;

  // Positive refs subtract one, negative refs count back from the end
  assign dec     = {1'b0, ref_val} - (REF_W+1)'(1);
  assign back    = {1'b1, {REF_W{1'b0}}} - {1'b0, ref_val};
  assign cnt_ext = (REF_W+1)'(count);

  assign pos_ok = (ref_val != '0) && !ref_val[REF_W-1] && (dec < cnt_ext);
  assign neg_ok = ref_val[REF_W-1] && (back <= cnt_ext);

  assign ok  = pos_ok || neg_ok;
  assign idx = ref_val[REF_W-1] ? (count - back[CW-1:0]) : dec[CW-1:0];

endmodule

// ===== rtl/core/corner_dedup_fan_triangulator.sv =====
// ----------------------------------------------------------------------------
// corner_dedup_fan_triangulator
// Checks corner references, dedups (position, texture) pairs through
// per-position node chains and fan-triangulates faces as corners stream in.
// ----------------------------------------------------------------------------
//  channel | handshake          | words
//  --------+--------------------+-------------------------------------------
//  input   | start & !busy      | func, pos_ref, uv_ref, uv_given, face_start
//  result  | out_valid strobe   | kind, indices, uv_present, is_new, error
//
//  After reset busy stays high while the head table is swept to empty.
//  A declaration, an ignored code or any word under a latched error finishes
//  in the accept cycle; a corner with a bad reference is busy until it fails.
//  A good corner resolves its position, then its texture, then walks its
//  chain in the node RAM, one link per cycle; a miss inserts a new node.
//  A fan triangle follows when one is due; busy holds until all is done.
//  Each result is strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module corner_dedup_fan_triangulator
  import cdft_pkg::*;
#(
  parameter int MAX_POSITIONS = DEF_MAX_POSITIONS,
  parameter int MAX_TEXCOORDS = DEF_MAX_TEXCOORDS,
  parameter int MAX_VERTICES  = DEF_MAX_VERTICES
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              in_func,
  input  logic signed [REF_W-1:0] in_pos_ref,
  input  logic signed [REF_W-1:0] in_uv_ref,
  input  logic                    in_uv_given,
  input  logic                    in_face_start,
  output logic                    out_valid,
  output logic [1:0]              out_kind,
  output logic [VIDX_W-1:0]       out_first_index,
  output logic [VIDX_W-1:0]       out_second_index,
  output logic [VIDX_W-1:0]       out_third_index,
  output logic [AIDX_W-1:0]       out_pos_index,
  output logic [AIDX_W-1:0]       out_uv_index,
  output logic                    out_uv_present,
  output logic                    out_is_new,
  output logic [1:0]              out_error_code,
  output logic                    out_last
);

  localparam int PCW = $clog2(MAX_POSITIONS + 1);
  localparam int PIW = $clog2(MAX_POSITIONS);
  localparam int TCW = $clog2(MAX_TEXCOORDS + 1);
  localparam int TIW = $clog2(MAX_TEXCOORDS);
  localparam int VCW = $clog2(MAX_VERTICES + 1);
  localparam int VIW = $clog2(MAX_VERTICES);
  localparam int RW  = (PCW > TCW) ? PCW : TCW;
  localparam int NW  = 1 + TIW + VCW;

  // Sequencer and counters
  state_t           state_r, state_nxt;
  logic [PIW-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [PCW-1:0]   pos_cnt_r, pos_cnt_nxt;
  logic [TCW-1:0]   uv_cnt_r, uv_cnt_nxt;
  logic [VCW-1:0]   node_cnt_r, node_cnt_nxt;
  err_t             sticky_r, sticky_nxt;
  phase_t           phase_r, phase_nxt;
  logic [VIDX_W-1:0] first_r, first_nxt;
  logic [VIDX_W-1:0] prev_r, prev_nxt;

  // Item registers
  logic [REF_W-1:0] pos_ref_r, pos_ref_nxt;
  logic [REF_W-1:0] uv_ref_r, uv_ref_nxt;
  logic             uv_given_r, uv_given_nxt;
  logic             face_start_r, face_start_nxt;
  logic [PIW-1:0]   pi_r, pi_nxt;
  logic [TIW-1:0]   ti_r, ti_nxt;
  logic [VCW-1:0]   head_r, head_nxt;
  logic [VCW-1:0]   link_r, link_nxt;
  logic [VIDX_W-1:0] vi_r, vi_nxt;

  // Result registers
  logic              out_valid_r, out_valid_nxt;
  kind_t             out_kind_r, out_kind_nxt;
  logic [VIDX_W-1:0] out_first_r, out_first_nxt;
  logic [VIDX_W-1:0] out_second_r, out_second_nxt;
  logic [VIDX_W-1:0] out_third_r, out_third_nxt;
  logic [AIDX_W-1:0] out_pos_r, out_pos_nxt;
  logic [AIDX_W-1:0] out_uv_r, out_uv_nxt;
  logic              out_uvp_r, out_uvp_nxt;
  logic              out_new_r, out_new_nxt;
  err_t              out_err_r, out_err_nxt;
  logic              out_last_r, out_last_nxt;

  // Memory ports
  logic           heads_we;
  logic [PIW-1:0] heads_waddr;
  logic [VCW-1:0] heads_wdata;
  logic [PIW-1:0] heads_raddr;
  logic [VCW-1:0] heads_rdata;
  logic           nodes_we;
  logic [VIW-1:0] nodes_waddr;
  logic [NW-1:0]  nodes_wdata;
  logic [VIW-1:0] nodes_raddr;
  logic [NW-1:0]  nodes_rdata;

  // Shared resolver
  logic [REF_W-1:0] rs_ref;
  logic [RW-1:0]    rs_count;
  logic             rs_ok;
  logic [RW-1:0]    rs_idx;

  // Decode helpers
  logic           acc;
  logic           clr_done;
  logic           pos_full;
  logic           uv_full;
  logic           node_full;
  logic           uv_bad;
  logic           tri_due;
  logic           nd_uvp;
  logic [TIW-1:0] nd_uv;
  logic [VCW-1:0] nd_next;
  logic           walk_hit;
  logic           ld_err;
  err_t           ld_code;
  logic           ld_vtx;
  logic [VIW-1:0] ld_idx;
  logic           ld_new;

  cdft_ram #(
    .WIDTH (VCW),
    .DEPTH (MAX_POSITIONS)
  ) u_heads (
    .clk   (clk),
    .we    (heads_we),
    .waddr (heads_waddr),
    .wdata (heads_wdata),
    .raddr (heads_raddr),
    .rdata (heads_rdata)
  );

  cdft_ram #(
    .WIDTH (NW),
    .DEPTH (MAX_VERTICES)
  ) u_nodes (
    .clk   (clk),
    .we    (nodes_we),
    .waddr (nodes_waddr),
    .wdata (nodes_wdata),
    .raddr (nodes_raddr),
    .rdata (nodes_rdata)
  );

  // Position ref first, texture ref next cycle
  assign rs_ref   = (state_r == ST_RES_UV) ? uv_ref_r : pos_ref_r;
  assign rs_count = (state_r == ST_RES_UV) ? RW'(uv_cnt_r) : RW'(pos_cnt_r);

  cdft_ref_resolve #(
    .CW (RW)
  ) u_resolve (
    .ref_val (rs_ref),
    .count   (rs_count),
    .ok      (rs_ok),
    .idx     (rs_idx)
  );

  // Shared decode
  assign acc       = start && !busy;
  assign clr_done  = (clr_cnt_r == PIW'(MAX_POSITIONS - 1));
  assign pos_full  = (pos_cnt_r >= PCW'(MAX_POSITIONS));
  assign uv_full   = (uv_cnt_r >= TCW'(MAX_TEXCOORDS));
  assign node_full = (node_cnt_r >= VCW'(MAX_VERTICES));
  assign uv_bad    = uv_given_r && !rs_ok;
  assign tri_due   = !face_start_r && (phase_r == PH_OPEN);
  assign nd_next   = nodes_rdata[VCW-1:0];
  assign nd_uv     = nodes_rdata[VCW +: TIW];
  assign nd_uvp    = nodes_rdata[NW-1];
  assign walk_hit  = (nd_uvp == uv_given_r) && (!uv_given_r || (nd_uv == ti_r));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (acc && (sticky_r == ERR_NONE) && (in_func == FUNC_CORNER)) begin
          state_nxt = ST_RES_POS;
        end
      end
      ST_RES_POS: begin
        state_nxt = rs_ok ? ST_RES_UV : ST_IDLE;
      end
      ST_RES_UV: begin
        if (uv_bad)                  state_nxt = ST_IDLE;
        else if (heads_rdata == '0)  state_nxt = ST_INSERT;
        else                         state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (walk_hit)            state_nxt = tri_due ? ST_FAN : ST_IDLE;
        else if (nd_next == '0)  state_nxt = ST_INSERT;
        else                     state_nxt = ST_WALK;
      end
      ST_INSERT: begin
        if (node_full) state_nxt = ST_IDLE;
        else           state_nxt = tri_due ? ST_FAN : ST_IDLE;
      end
      ST_FAN: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, memory controls and result words
  always_comb begin
    clr_cnt_nxt    = clr_cnt_r;
    pos_cnt_nxt    = pos_cnt_r;
    uv_cnt_nxt     = uv_cnt_r;
    node_cnt_nxt   = node_cnt_r;
    sticky_nxt     = sticky_r;
    phase_nxt      = phase_r;
    first_nxt      = first_r;
    prev_nxt       = prev_r;
    pos_ref_nxt    = pos_ref_r;
    uv_ref_nxt     = uv_ref_r;
    uv_given_nxt   = uv_given_r;
    face_start_nxt = face_start_r;
    pi_nxt         = pi_r;
    ti_nxt         = ti_r;
    head_nxt       = head_r;
    link_nxt       = link_r;
    vi_nxt         = vi_r;
    out_valid_nxt  = 1'b0;
    out_kind_nxt   = out_kind_r;
    out_first_nxt  = out_first_r;
    out_second_nxt = out_second_r;
    out_third_nxt  = out_third_r;
    out_pos_nxt    = out_pos_r;
    out_uv_nxt     = out_uv_r;
    out_uvp_nxt    = out_uvp_r;
    out_new_nxt    = out_new_r;
    out_err_nxt    = out_err_r;
    out_last_nxt   = out_last_r;
    heads_we       = 1'b0;
    heads_waddr    = pi_r;
    heads_wdata    = '0;
    heads_raddr    = pi_r;
    nodes_we       = 1'b0;
    nodes_waddr    = VIW'(node_cnt_r);
    nodes_wdata    = {uv_given_r, ti_r, head_r};
    nodes_raddr    = VIW'(link_r - VCW'(1));
    ld_err         = 1'b0;
    ld_code        = ERR_NONE;
    ld_vtx         = 1'b0;
    ld_idx         = '0;
    ld_new         = 1'b0;

    unique case (state_r)
      // Sweep the head table to empty
      ST_CLEAR: begin
        heads_we    = 1'b1;
        heads_waddr = clr_cnt_r;
        heads_wdata = '0;
        clr_cnt_nxt = clr_cnt_r + PIW'(1);
      end
      // Take a word; declarations finish here
      ST_IDLE: begin
        if (acc) begin
          pos_ref_nxt    = in_pos_ref;
          uv_ref_nxt     = in_uv_ref;
          uv_given_nxt   = in_uv_given;
          face_start_nxt = in_face_start;
          if (sticky_r != ERR_NONE) begin
            ld_err  = 1'b1;
            ld_code = sticky_r;
          end else if (in_func == FUNC_POS) begin
            if (pos_full) begin
              ld_err  = 1'b1;
              ld_code = ERR_FULL;
            end else begin
              pos_cnt_nxt = pos_cnt_r + PCW'(1);
            end
          end else if (in_func == FUNC_UV) begin
            if (uv_full) begin
              ld_err  = 1'b1;
              ld_code = ERR_FULL;
            end else begin
              uv_cnt_nxt = uv_cnt_r + TCW'(1);
            end
          end
        end
      end
      // Resolve position, fetch chain head
      ST_RES_POS: begin
        if (!rs_ok) begin
          ld_err  = 1'b1;
          ld_code = ERR_BAD_REF;
        end else begin
          pi_nxt      = PIW'(rs_idx);
          heads_raddr = PIW'(rs_idx);
        end
      end
      // Resolve texture, start the walk
      ST_RES_UV: begin
        head_nxt = heads_rdata;
        link_nxt = heads_rdata;
        ti_nxt   = uv_given_r ? TIW'(rs_idx) : '0;
        nodes_raddr = VIW'(heads_rdata - VCW'(1));
        if (uv_bad) begin
          ld_err  = 1'b1;
          ld_code = ERR_BAD_REF;
        end
      end
      // One chain link per cycle
      ST_WALK: begin
        nodes_raddr = VIW'(nd_next - VCW'(1));
        if (walk_hit) begin
          ld_vtx = 1'b1;
          ld_idx = VIW'(link_r - VCW'(1));
        end else begin
          link_nxt = nd_next;
        end
      end
      // New node goes to the chain head
      ST_INSERT: begin
        if (node_full) begin
          ld_err  = 1'b1;
          ld_code = ERR_FULL;
        end else begin
          nodes_we     = 1'b1;
          heads_we     = 1'b1;
          heads_waddr  = pi_r;
          heads_wdata  = node_cnt_r + VCW'(1);
          node_cnt_nxt = node_cnt_r + VCW'(1);
          ld_vtx       = 1'b1;
          ld_idx       = VIW'(node_cnt_r);
          ld_new       = 1'b1;
        end
      end
      // Fan triangle (first, previous, current)
      ST_FAN: begin
        out_valid_nxt  = 1'b1;
        out_kind_nxt   = KIND_TRIANGLE;
        out_first_nxt  = first_r;
        out_second_nxt = prev_r;
        out_third_nxt  = vi_r;
        out_pos_nxt    = '0;
        out_uv_nxt     = '0;
        out_uvp_nxt    = 1'b0;
        out_new_nxt    = 1'b0;
        out_err_nxt    = ERR_NONE;
        out_last_nxt   = 1'b1;
        prev_nxt       = vi_r;
      end
      default: ;
    endcase

    // Error word, latched for good
    if (ld_err) begin
      sticky_nxt     = ld_code;
      out_valid_nxt  = 1'b1;
      out_kind_nxt   = KIND_ERROR;
      out_first_nxt  = '0;
      out_second_nxt = '0;
      out_third_nxt  = '0;
      out_pos_nxt    = '0;
      out_uv_nxt     = '0;
      out_uvp_nxt    = 1'b0;
      out_new_nxt    = 1'b0;
      out_err_nxt    = ld_code;
      out_last_nxt   = 1'b1;
    end

    // Vertex word and fan bookkeeping
    if (ld_vtx) begin
      vi_nxt         = VIDX_W'(ld_idx);
      out_valid_nxt  = 1'b1;
      out_kind_nxt   = KIND_VERTEX;
      out_first_nxt  = VIDX_W'(ld_idx);
      out_second_nxt = '0;
      out_third_nxt  = '0;
      out_pos_nxt    = AIDX_W'(pi_r);
      out_uv_nxt     = AIDX_W'(ti_r);
      out_uvp_nxt    = uv_given_r;
      out_new_nxt    = ld_new;
      out_err_nxt    = ERR_NONE;
      out_last_nxt   = !tri_due;
      if (face_start_r || (phase_r == PH_NONE)) begin
        first_nxt = VIDX_W'(ld_idx);
        prev_nxt  = VIDX_W'(ld_idx);
        phase_nxt = PH_ONE;
      end else if (phase_r == PH_ONE) begin
        prev_nxt  = VIDX_W'(ld_idx);
        phase_nxt = PH_OPEN;
      end
    end
  end

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      pos_cnt_r   <= '0;
      uv_cnt_r    <= '0;
      node_cnt_r  <= '0;
      sticky_r    <= ERR_NONE;
      phase_r     <= PH_NONE;
      first_r     <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      pos_cnt_r   <= pos_cnt_nxt;
      uv_cnt_r    <= uv_cnt_nxt;
      node_cnt_r  <= node_cnt_nxt;
      sticky_r    <= sticky_nxt;
      phase_r     <= phase_nxt;
      first_r     <= first_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_ref_r    <= pos_ref_nxt;
    uv_ref_r     <= uv_ref_nxt;
    uv_given_r   <= uv_given_nxt;
    face_start_r <= face_start_nxt;
    pi_r         <= pi_nxt;
    ti_r         <= ti_nxt;
    head_r       <= head_nxt;
    link_r       <= link_nxt;
    vi_r         <= vi_nxt;
    out_kind_r   <= out_kind_nxt;
    out_first_r  <= out_first_nxt;
    out_second_r <= out_second_nxt;
    out_third_r  <= out_third_nxt;
    out_pos_r    <= out_pos_nxt;
    out_uv_r     <= out_uv_nxt;
    out_uvp_r    <= out_uvp_nxt;
    out_new_r    <= out_new_nxt;
    out_err_r    <= out_err_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Ports
  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_first_index  = out_first_r;
  assign out_second_index = out_second_r;
  assign out_third_index  = out_third_r;
  assign out_pos_index    = out_pos_r;
  assign out_uv_index     = out_uv_r;
  assign out_uv_present   = out_uvp_r;
  assign out_is_new       = out_new_r;
  assign out_error_code   = out_err_r;
  assign out_last         = out_last_r;

`ifndef NO_ASSERTIONS
  // No word leaves during the head sweep
  a_quiet_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !out_valid_r)
    else $error("result strobed during head sweep");

  // Node count never passes the store size
  a_node_bound: assert property (@(posedge clk) disable iff (!rst_n)
    node_cnt_r <= VCW'(MAX_VERTICES))
    else $error("node count overflow");

  // The fan cycle shows the vertex word that opens a two-word item
  a_fan_vertex: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FAN) |-> (out_valid_r && (out_kind_r == KIND_VERTEX) && !out_last_r))
    else $error("fan step without preceding vertex word");

  // A latched error holds until reset
  a_sticky_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (sticky_r != ERR_NONE) |=> (sticky_r == $past(sticky_r)))
    else $error("sticky error changed");

  // Error words carry a code and end the item
  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == KIND_ERROR)) |-> ((out_err_r != ERR_NONE) && out_last_r))
    else $error("malformed error word");
`endif

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for corner_dedup_fan_triangulator. A queue of mesh
// words (declarations, corners, ignored codes) feeds a falling-edge driver.
// A rising-edge monitor mirrors the dedup chains and the face fan to predict
// every result word, and compares the strobed results field by field. The run
// ends with one sticky error, picked at random, followed by a few words that
// must all echo it.
// ----------------------------------------------------------------------------
module tb;
  import cdft_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int TAIL_CYCLES = 64;
  localparam logic [1:0] FUNC_IGNORED = 2'd3;

  typedef struct packed {
    logic        drain;
    logic [6:0]  idle_pct;
    logic [1:0]  func;
    logic [31:0] pos_ref;
    logic [31:0] uv_ref;
    logic        uv_given;
    logic        face_start;
  } mesh_word_t;

  typedef struct packed {
    kind_t       kind;
    logic [12:0] first_idx;
    logic [12:0] second_idx;
    logic [12:0] third_idx;
    logic [11:0] pos_idx;
    logic [11:0] uv_idx;
    logic        uv_present;
    logic        is_new;
    err_t        err;
    logic        last;
  } result_t;

  typedef enum int {
    END_BAD_POS,
    END_BAD_UV
  } end_case_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [1:0]        in_func;
  logic signed [31:0] in_pos_ref;
  logic signed [31:0] in_uv_ref;
  logic              in_uv_given;
  logic              in_face_start;
  logic              out_valid;
  logic [1:0]        out_kind;
  logic [12:0]       out_first_index;
  logic [12:0]       out_second_index;
  logic [12:0]       out_third_index;
  logic [11:0]       out_pos_index;
  logic [11:0]       out_uv_index;
  logic              out_uv_present;
  logic              out_is_new;
  logic [1:0]        out_error_code;
  logic              out_last;

  corner_dedup_fan_triangulator i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_pos_ref       (in_pos_ref),
    .in_uv_ref        (in_uv_ref),
    .in_uv_given      (in_uv_given),
    .in_face_start    (in_face_start),
    .out_valid        (out_valid),
    .out_kind         (out_kind),
    .out_first_index  (out_first_index),
    .out_second_index (out_second_index),
    .out_third_index  (out_third_index),
    .out_pos_index    (out_pos_index),
    .out_uv_index     (out_uv_index),
    .out_uv_present   (out_uv_present),
    .out_is_new       (out_is_new),
    .out_error_code   (out_error_code),
    .out_last         (out_last)
  );

  // Word queues
  mesh_word_t mesh_items[$];
  result_t    expected_words[$];

  // Mirror of the block state
  int   pos_total   = 0;
  int   uv_total    = 0;
  int   node_total  = 0;
  int   head_of[DEF_MAX_POSITIONS];
  bit   node_has_uv[DEF_MAX_VERTICES];
  int   node_uv[DEF_MAX_VERTICES];
  int   node_link[DEF_MAX_VERTICES];
  phase_t      fan_phase   = PH_NONE;
  logic [12:0] fan_first   = '0;
  logic [12:0] fan_prev    = '0;
  err_t        latched_err = ERR_NONE;

  // Generator side bookkeeping
  int          gen_pos = 0;
  int          gen_uv  = 0;
  logic [6:0]  gen_idle = 7'd10;
  int unsigned words_queued = 0;
  int unsigned items_made   = 0;
  string       end_note;

  // Monitor bookkeeping
  logic        took_word = 1'b0;
  int unsigned words_taken  = 0;
  int unsigned bad_words    = 0;
  int unsigned stall_cycles = 0;
  int unsigned n_vertex = 0, n_new = 0, n_tri = 0, n_err = 0;
  mesh_word_t  drv_word;
  mesh_word_t  taken_word;
  result_t     want;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // 1-based or counted back from the live count; zero is never good
  function automatic bit resolve_ref(input logic [31:0] r, input int cnt, output int idx);
    longint back;
    idx = 0;
    if (r == 32'd0) return 1'b0;
    if (!r[31]) begin
      if (int'(r) - 1 >= cnt) return 1'b0;
      idx = int'(r) - 1;
      return 1'b1;
    end
    back = 64'h1_0000_0000 - {32'd0, r};
    if (back > cnt) return 1'b0;
    idx = cnt - int'(back);
    return 1'b1;
  endfunction

  function automatic void push_error(input err_t code);
    result_t e;
    e = '0;
    e.kind = KIND_ERROR;
    e.err  = code;
    e.last = 1'b1;
    expected_words.push_back(e);
  endfunction

  function automatic void raise_error(input err_t code);
    latched_err = code;
    push_error(code);
  endfunction

  // Dedup the corner through its position chain, then step the face fan
  function automatic void resolve_and_fan(input mesh_word_t w);
    int      pi, ti, link, vi;
    bit      hit;
    result_t v, t;
    pi = 0; ti = 0; vi = 0; hit = 1'b0;
    v = '0; t = '0;
    if (latched_err != ERR_NONE) begin
      push_error(latched_err);
      return;
    end
    case (w.func)
      FUNC_POS: begin
        if (pos_total >= DEF_MAX_POSITIONS) raise_error(ERR_FULL);
        else pos_total++;
      end
      FUNC_UV: begin
        if (uv_total >= DEF_MAX_TEXCOORDS) raise_error(ERR_FULL);
        else uv_total++;
      end
      FUNC_CORNER: begin
        if (!resolve_ref(w.pos_ref, pos_total, pi)) begin
          raise_error(ERR_BAD_REF);
          return;
        end
        if (w.uv_given && !resolve_ref(w.uv_ref, uv_total, ti)) begin
          raise_error(ERR_BAD_REF);
          return;
        end
        if (!w.uv_given) ti = 0;
        link = head_of[pi];
        while (link != 0 && !hit) begin
          if (node_has_uv[link-1] == w.uv_given &&
              (!w.uv_given || node_uv[link-1] == ti)) begin
            vi  = link - 1;
            hit = 1'b1;
          end else begin
            link = node_link[link-1];
          end
        end
        if (!hit) begin
          if (node_total >= DEF_MAX_VERTICES) begin
            raise_error(ERR_FULL);
            return;
          end
          vi              = node_total;
          node_has_uv[vi] = w.uv_given;
          node_uv[vi]     = ti;
          node_link[vi]   = head_of[pi];
          head_of[pi]     = vi + 1;
          node_total++;
        end
        v.kind       = KIND_VERTEX;
        v.first_idx  = 13'(vi);
        v.pos_idx    = 12'(pi);
        v.uv_idx     = 12'(ti);
        v.uv_present = w.uv_given;
        v.is_new     = !hit;
        if (w.face_start || fan_phase == PH_NONE) begin
          fan_first = 13'(vi);
          fan_prev  = 13'(vi);
          fan_phase = PH_ONE;
          v.last    = 1'b1;
          expected_words.push_back(v);
        end else if (fan_phase == PH_ONE) begin
          fan_prev  = 13'(vi);
          fan_phase = PH_OPEN;
          v.last    = 1'b1;
          expected_words.push_back(v);
        end else begin
          expected_words.push_back(v);
          t.kind       = KIND_TRIANGLE;
          t.first_idx  = fan_first;
          t.second_idx = fan_prev;
          t.third_idx  = 13'(vi);
          t.last       = 1'b1;
          expected_words.push_back(t);
          fan_prev = 13'(vi);
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  task automatic push_word(input logic [1:0] f, input logic [31:0] p,
                           input logic [31:0] u, input bit ug, input bit fs);
    mesh_word_t w;
    w = '0;
    w.idle_pct   = gen_idle;
    w.func       = f;
    w.pos_ref    = p;
    w.uv_ref     = u;
    w.uv_given   = ug;
    w.face_start = fs;
    mesh_items.push_back(w);
    words_queued++;
    if (f != FUNC_IGNORED) items_made++;
  endtask

  task automatic add_drain();
    mesh_word_t w;
    w = '0;
    w.drain = 1'b1;
    mesh_items.push_back(w);
  endtask

  task automatic add_decl(input func_t f);
    if (f == FUNC_POS) gen_pos++;
    else gen_uv++;
    push_word(f, $urandom, $urandom, $urandom_range(0, 1), $urandom_range(0, 1));
  endtask

  task automatic add_noise();
    push_word(FUNC_IGNORED, $urandom, $urandom, $urandom_range(0, 1),
              $urandom_range(0, 1));
  endtask

  // Mostly recent entries so that pairs repeat and chains get walked
  function automatic int pick_idx(input int cnt);
    int span, roll;
    span = (cnt < 6) ? cnt : 6;
    roll = $urandom_range(0, 99);
    if (roll < 65) return cnt - 1 - int'($urandom_range(0, span - 1));
    if (roll < 72) return roll[0] ? 0 : cnt - 1;
    return $urandom_range(0, cnt - 1);
  endfunction

  function automatic logic [31:0] encode_ref(input int idx, input int cnt);
    return $urandom_range(0, 1) ? 32'(idx + 1) : 32'(idx - cnt);
  endfunction

  task automatic add_corner(input bit fs);
    int pi, ti;
    bit ug;
    pi = pick_idx(gen_pos);
    ti = pick_idx(gen_uv);
    ug = $urandom_range(0, 1);
    push_word(FUNC_CORNER, encode_ref(pi, gen_pos),
              ug ? encode_ref(ti, gen_uv) : $urandom, ug, fs);
  endtask

  // Faces of random length, with declarations and ignored words mixed in
  task automatic random_mesh(input int unsigned target);
    int roll, len, k;
    while (items_made < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        if (roll[0] && gen_pos < DEF_MAX_POSITIONS) add_decl(FUNC_POS);
        else if (gen_uv < DEF_MAX_TEXCOORDS) add_decl(FUNC_UV);
      end else if (roll < 9) begin
        add_noise();
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 5) len = 1;
        else if (roll < 15) len = 2;
        else if (roll < 90) len = $urandom_range(3, 6);
        else len = $urandom_range(7, 12);
        for (k = 0; k < len; k++) begin
          roll = $urandom_range(0, 99);
          if (roll < 4 && gen_pos < DEF_MAX_POSITIONS) add_decl(FUNC_POS);
          else if (roll < 6) add_noise();
          add_corner(k == 0 ? ($urandom_range(0, 9) != 0) : 1'b0);
        end
      end
    end
  endtask

  function automatic logic [31:0] bad_ref(input int cnt);
    case ($urandom_range(0, 4))
      0:       return 32'd0;
      1:       return 32'(cnt + 1);
      2:       return 32'(-(cnt + 1));
      3:       return 32'h8000_0000;
      default: return 32'h7FFF_FFFF;
    endcase
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, got_v);
      bad_words++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock and reset
  // ---------------------------------------------------------------------------
  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_func       = '0;
    in_pos_ref    = '0;
    in_uv_ref     = '0;
    in_uv_given   = 1'b0;
    in_face_start = 1'b0;
    fork
      forever #5 clk = ~clk;
      begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
      end
    join_none
  end

  // ---------------------------------------------------------------------------
  // Driver: next word at the falling edge once the last one was taken
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n && (!start || took_word)) begin
      if (mesh_items.size() != 0 && mesh_items[0].drain) begin
        // hold off until every result in flight has come back
        if (expected_words.size() == 0) void'(mesh_items.pop_front());
        start <= 1'b0;
      end else if (mesh_items.size() != 0 &&
                   $urandom_range(0, 99) >= mesh_items[0].idle_pct) begin
        drv_word       = mesh_items.pop_front();
        start         <= 1'b1;
        in_func       <= drv_word.func;
        in_pos_ref    <= drv_word.pos_ref;
        in_uv_ref     <= drv_word.uv_ref;
        in_uv_given   <= drv_word.uv_given;
        in_face_start <= drv_word.face_start;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check strobed results, predict accepted words, watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    took_word <= rst_n && start && !busy;
    if (rst_n && out_valid) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result word, kind %0d", $time, out_kind);
        bad_words++;
      end else begin
        want = expected_words.pop_front();
        check_field("kind", want.kind, out_kind);
        check_field("first_index", want.first_idx, out_first_index);
        check_field("second_index", want.second_idx, out_second_index);
        check_field("third_index", want.third_idx, out_third_index);
        check_field("pos_index", want.pos_idx, out_pos_index);
        check_field("uv_index", want.uv_idx, out_uv_index);
        check_field("uv_present", want.uv_present, out_uv_present);
        check_field("is_new", want.is_new, out_is_new);
        check_field("error_code", want.err, out_error_code);
        check_field("last", want.last, out_last);
        case (want.kind)
          KIND_VERTEX: begin
            n_vertex++;
            if (want.is_new) n_new++;
          end
          KIND_TRIANGLE: n_tri++;
          default:       n_err++;
        endcase
      end
    end
    if (rst_n && start && !busy) begin
      taken_word            = '0;
      taken_word.func       = in_func;
      taken_word.pos_ref    = in_pos_ref;
      taken_word.uv_ref     = in_uv_ref;
      taken_word.uv_given   = in_uv_given;
      taken_word.face_start = in_face_start;
      resolve_and_fan(taken_word);
      words_taken++;
    end
    // no progress for too long: hung handshake or lost results
    if (rst_n && !(start && !busy) && !out_valid) stall_cycles++;
    else stall_cycles = 0;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time,
               expected_words.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    end_case_t ending;

    // directed: ignored code, declarations, open face without face_start
    gen_idle = 7'd10;
    add_noise();
    add_decl(FUNC_POS); add_decl(FUNC_POS); add_decl(FUNC_POS);
    add_decl(FUNC_UV);  add_decl(FUNC_UV);
    push_word(FUNC_CORNER, 32'd1, 32'h8000_0000, 1'b0, 1'b0);
    push_word(FUNC_CORNER, -32'sd1, 32'd1, 1'b1, 1'b0);
    push_word(FUNC_CORNER, 32'd3, -32'sd2, 1'b1, 1'b0);
    push_word(FUNC_CORNER, 32'd1, 32'h7FFF_FFFF, 1'b0, 1'b0);   // reused vertex
    // declaration and ignored word inside an open face
    add_decl(FUNC_POS);
    add_noise();
    push_word(FUNC_CORNER, -32'sd4, -32'sd1, 1'b1, 1'b0);
    // short faces: one corner, then two
    push_word(FUNC_CORNER, 32'd2, 32'd1, 1'b1, 1'b1);
    push_word(FUNC_CORNER, -32'sd1, 32'd0, 1'b0, 1'b1);
    push_word(FUNC_CORNER, 32'd4, 32'd2, 1'b1, 1'b0);
    // pentagon fan
    push_word(FUNC_CORNER, 32'd1, 32'd1, 1'b1, 1'b1);
    push_word(FUNC_CORNER, 32'd2, -32'sd2, 1'b1, 1'b0);
    push_word(FUNC_CORNER, 32'd3, 32'd0, 1'b0, 1'b0);
    push_word(FUNC_CORNER, 32'd4, 32'd2, 1'b1, 1'b0);
    push_word(FUNC_CORNER, -32'sd1, 32'd1, 1'b1, 1'b0);

    // random, light sender gaps
    random_mesh(380);
    add_drain();
    // random, heavy sender gaps
    gen_idle = 7'd62;
    random_mesh(680);
    add_drain();
    // random, no gaps
    gen_idle = 7'd0;
    random_mesh(950);
    add_drain();

    // one terminal error, then words that must echo it
    ending = end_case_t'($urandom_range(0, 1));
    case (ending)
      END_BAD_POS: begin
        end_note = "bad position reference";
        push_word(FUNC_CORNER, bad_ref(gen_pos), 32'd1, 1'b1, $urandom_range(0, 1));
      end
      default: begin
        end_note = "bad texture reference";
        push_word(FUNC_CORNER, 32'd1, bad_ref(gen_uv), 1'b1, $urandom_range(0, 1));
      end
    endcase
    add_decl(FUNC_POS);
    add_decl(FUNC_UV);
    push_word(FUNC_CORNER, 32'd1, 32'd1, 1'b1, 1'b1);
    add_noise();

    while (words_taken != words_queued) @(negedge clk);
    while (expected_words.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Sent %0d words: %0d vertex results (%0d new), %0d triangles, %0d errors.",
             words_taken, n_vertex, n_new, n_tri, n_err);
    $display("Declared %0d positions and %0d texture coordinates; run ended on %s.",
             gen_pos, gen_uv, end_note);
    if (bad_words == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/cdft_pkg.sv
rtl/core/cdft_ram.sv
rtl/core/cdft_ref_resolve.sv
rtl/core/corner_dedup_fan_triangulator.sv
tb/sv/tb.sv
